// ===== src/lkvc_pkg.sv =====
// Package for the LRU key/value cache core.
// Holds field widths, operation codes, update command encodings and the token flag type.
// No dependencies.
package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET    = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_TOUCH,
        UPD_FRESH
    } t_upd_mode;

    typedef enum logic [1:0] {
        SEL_HIT,
        SEL_FREE,
        SEL_LRU
    } t_upd_sel;

    typedef struct packed {
        logic      valid;
        t_upd_mode mode;
        t_upd_sel  sel;
        logic      write;
    } t_upd_cmd;

    typedef struct packed {
        logic hit_found;
        logic free_found;
    } t_tok_flags;

endpackage

// ===== src/lkvc_req_if.sv =====
// Request channel of the LRU key/value cache: op, key and value.
// Depends on lkvc_pkg.
interface lkvc_req_if;
    import lkvc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// ===== src/lkvc_rsp_if.sv =====
// Response channel of the LRU key/value cache: hit flag and read value.
// Depends on lkvc_pkg.
interface lkvc_rsp_if;
    import lkvc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== src/lkvc_cell.sv =====
// One cache entry: key, value, valid mark and age rank, plus one stage of the search token.
// Marks itself as hit, free or LRU entry as the token passes; applies broadcast updates.
// Depends on lkvc_pkg.
module lkvc_cell #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [$clog2(ENTRIES)-1:0]        i_lru_rank,
    input  logic                              i_tok_valid,
    input  lkvc_pkg::t_tok_flags              i_tok,
    input  logic [$clog2(ENTRIES)-1:0]        i_tok_rank,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_tok_value,
    output logic                              o_tok_valid,
    output lkvc_pkg::t_tok_flags              o_tok,
    output logic [$clog2(ENTRIES)-1:0]        o_tok_rank,
    output logic signed [lkvc_pkg::VAL_W-1:0] o_tok_value,
    input  lkvc_pkg::t_upd_cmd                i_upd,
    input  logic [$clog2(ENTRIES)-1:0]        i_upd_rank,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_upd_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_upd_value
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);

    logic                    r_valid;
    logic [RANK_W-1:0]       r_rank;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_hit_mark;
    logic                    r_free_mark;
    logic                    r_lru_mark;
    logic                    r_tok_valid;
    t_tok_flags              r_tok;
    logic [RANK_W-1:0]       r_tok_rank;
    logic signed [VAL_W-1:0] r_tok_value;

    logic match;
    logic claim_free;
    logic target;
    logic wr_data;

    assign match      = r_valid && (r_key == i_key) && !i_tok.hit_found;
    assign claim_free = !r_valid && !i_tok.free_found;

    always_comb begin
        case (i_upd.sel)
            SEL_HIT:  target = r_hit_mark;
            SEL_FREE: target = r_free_mark;
            SEL_LRU:  target = r_lru_mark;
            default:  target = 1'b0;
        endcase
    end

    assign wr_data = i_upd.valid && target &&
                     ((i_upd.mode == UPD_FRESH) || ((i_upd.mode == UPD_TOUCH) && i_upd.write));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_rank      <= '0;
            r_hit_mark  <= 1'b0;
            r_free_mark <= 1'b0;
            r_lru_mark  <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
            if (i_tok_valid) begin
                r_hit_mark  <= match;
                r_free_mark <= claim_free;
                r_lru_mark  <= r_valid && (r_rank == i_lru_rank);
            end
            if (i_upd.valid) begin
                case (i_upd.mode)
                    UPD_TOUCH: begin
                        if (target) begin
                            r_rank <= '0;
                        end else if (r_valid && (r_rank < i_upd_rank)) begin
                            r_rank <= r_rank + RANK_W'(1);
                        end
                    end
                    UPD_FRESH: begin
                        if (target) begin
                            r_rank  <= '0;
                            r_valid <= 1'b1;
                        end else if (r_valid) begin
                            r_rank <= r_rank + RANK_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_valid) begin
            r_tok.hit_found  <= i_tok.hit_found | match;
            r_tok.free_found <= i_tok.free_found | claim_free;
            r_tok_rank       <= match ? r_rank : i_tok_rank;
            r_tok_value      <= match ? r_value : i_tok_value;
        end
        if (wr_data) begin
            r_key   <= i_upd_key;
            r_value <= i_upd_value;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;
    assign o_tok_rank  = r_tok_rank;
    assign o_tok_value = r_tok_value;
endmodule

// ===== src/lru_key_value_cache_core.sv =====
// Top level of the fully associative LRU key/value cache: chain of entry cells and control.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and lkvc_cell.
//
//   channel   dir   handshake       payload
//   i_req     in    valid/ready     op, key, value
//   o_rsp     out   valid/ready     hit, read_value
//   cfg       in    i_cfg_we        i_cfg_wdata (capacity)
//
// An item passes through accept, a search token walking one cell per cycle down the
// chain of ENTRIES cells, a turnaround, and a commit that updates all cells.
// Reset clears all valid marks and ranks directly; no clearing pass.
// A new item is accepted while a result still waits on o_rsp; its commit holds until
// the output register is free.
module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lkvc_req_if.sink                          i_req,
    lkvc_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cfg_wdata
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    t_state                  r_state;
    logic [CAP_W-1:0]        r_capacity;
    logic [CNT_W-1:0]        r_used;
    logic                    r_launch;
    logic                    r_op;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_rsp_valid;
    logic                    r_rsp_hit;
    logic signed [VAL_W-1:0] r_rsp_value;

    logic                    chain_valid [ENTRIES+1];
    t_tok_flags              chain_tok   [ENTRIES+1];
    logic [RANK_W-1:0]       chain_rank  [ENTRIES+1];
    logic signed [VAL_W-1:0] chain_value [ENTRIES+1];

    t_upd_cmd                upd;
    logic [RANK_W-1:0]       upd_rank;
    logic [RANK_W-1:0]       lru_rank;
    logic [CMP_W-1:0]        cap_eff;
    logic                    room;
    logic                    out_free;
    logic                    commit;
    logic                    last_hit;
    logic                    accept;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_rsp_valid || o_rsp.ready;
    assign commit   = (r_state == ST_FINISH) && out_free;
    assign lru_rank = RANK_W'(r_used - CNT_W'(1));
    assign last_hit = chain_tok[ENTRIES].hit_found;

    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(r_capacity);
        end
    end

    assign room = CMP_W'(r_used) < cap_eff;

    always_comb begin
        upd.valid = commit;
        upd.mode  = UPD_NONE;
        upd.sel   = SEL_HIT;
        upd.write = (r_op == OP_SET);
        upd_rank  = chain_rank[ENTRIES];
        if (last_hit) begin
            upd.mode = UPD_TOUCH;
        end else if (r_op == OP_SET) begin
            if (room) begin
                if (chain_tok[ENTRIES].free_found) begin
                    upd.mode = UPD_FRESH;
                    upd.sel  = SEL_FREE;
                end
            end else begin
                upd.mode = UPD_TOUCH;
                upd.sel  = SEL_LRU;
                upd_rank = lru_rank;
            end
        end
    end

    assign chain_valid[0]          = r_launch;
    assign chain_tok[0].hit_found  = 1'b0;
    assign chain_tok[0].free_found = 1'b0;
    assign chain_rank[0]           = '0;
    assign chain_value[0]          = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell #(
            .ENTRIES (ENTRIES)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_lru_rank  (lru_rank),
            .i_tok_valid (chain_valid[g]),
            .i_tok       (chain_tok[g]),
            .i_tok_rank  (chain_rank[g]),
            .i_tok_value (chain_value[g]),
            .o_tok_valid (chain_valid[g+1]),
            .o_tok       (chain_tok[g+1]),
            .o_tok_rank  (chain_rank[g+1]),
            .o_tok_value (chain_value[g+1]),
            .i_upd       (upd),
            .i_upd_rank  (upd_rank),
            .i_upd_key   (r_key),
            .i_upd_value (r_value)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_capacity  <= CAP_RESET;
            r_used      <= '0;
            r_launch    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (commit) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_launch <= 1'b1;
                        r_state  <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (chain_valid[ENTRIES]) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (commit) begin
                        if (upd.mode == UPD_FRESH) begin
                            r_used <= r_used + CNT_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_req.op;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        if (commit) begin
            r_rsp_hit   <= last_hit;
            r_rsp_value <= ((r_op == OP_GET) && last_hit) ? chain_value[ENTRIES] : '0;
        end
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.hit        = r_rsp_hit;
    assign o_rsp.read_value = r_rsp_value;
endmodule

// ===== sim/tb_lru_key_value_cache_core.sv =====
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache_core: random and directed get/set items with
// capacity changes, checked against a recency-rank cache predictor. Uses lkvc_pkg,
// lkvc_req_if, lkvc_rsp_if and the core itself.
module tb_lru_key_value_cache_core;
    import lkvc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN       = ENTRIES + 8;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lkvc_req_if req_if();
    lkvc_rsp_if rsp_if();

    lru_key_value_cache_core #(.ENTRIES(ENTRIES)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_request request_q[$];
    t_reply   pending_replies[$];

    logic [KEY_W-1:0] slot_key[ENTRIES];
    logic [VAL_W-1:0] slot_val[ENTRIES];
    logic             slot_used[ENTRIES];
    logic [3:0]       slot_age[ENTRIES];
    int               fill_count;
    logic [CAP_W-1:0] cap_setting;

    int  accepted_n = 0;
    int  rsp_count  = 0;
    int  hits_seen  = 0;
    int  errors     = 0;
    int  cycles     = 0;
    int  settings_n = 1;
    bit  calm       = 1'b0;

    int  send_gap;
    int  ready_gap;
    int  stall_left;
    int  next_stall_at;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic promote(input int e);
        logic [3:0] old;
        old = slot_age[e];
        for (int i = 0; i < ENTRIES; i++)
            if (i != e && slot_used[i] && slot_age[i] < old) slot_age[i]++;
        slot_age[e] = 4'd0;
    endtask

    task automatic apply_request(input t_request r, output t_reply rep);
        int found;
        int victim;
        int eff;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_used[i] && slot_key[i] == r.key) found = i;
        eff = (cap_setting == 0) ? 1 : ((cap_setting > ENTRIES) ? ENTRIES : cap_setting);
        rep.hit = (found >= 0);
        rep.read_value = '0;
        if (r.op == OP_GET) begin
            if (found >= 0) begin
                rep.read_value = slot_val[found];
                promote(found);
            end
        end else if (found >= 0) begin
            slot_val[found] = r.value;
            promote(found);
        end else if (fill_count < eff) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (victim < 0 && !slot_used[i]) victim = i;
            if (victim >= 0) begin
                slot_key[victim] = r.key;
                slot_val[victim] = r.value;
                for (int i = 0; i < ENTRIES; i++)
                    if (i != victim && slot_used[i]) slot_age[i]++;
                slot_age[victim] = 4'd0;
                slot_used[victim] = 1'b1;
                fill_count++;
            end
        end else begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
            if (victim >= 0) begin
                slot_key[victim] = r.key;
                slot_val[victim] = r.value;
                promote(victim);
            end
        end
    endtask

    // Predict on every accepted item; track capacity writes.
    always @(posedge i_clk) begin
        t_request r;
        t_reply   rep;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 4'd0;
            end
            fill_count  = 0;
            cap_setting = CAP_RESET;
        end else begin
            if (i_cfg_we) cap_setting = i_cfg_wdata;
            if (req_if.valid && req_if.ready) begin
                r.op    = req_if.op;
                r.key   = req_if.key;
                r.value = req_if.value;
                apply_request(r, rep);
                pending_replies.push_back(rep);
                accepted_n++;
            end
        end
    end

    always @(posedge i_clk) begin
        t_request cur;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                cur = request_q.pop_front();
                req_if.valid <= 1'b1;
                req_if.op    <= cur.op;
                req_if.key   <= cur.key;
                req_if.value <= cur.value;
                send_gap = pick_gap();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Hold off for a long stretch now and then so the core backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            ready_gap = 0;
            stall_left = 0;
            next_stall_at = 300;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= (stall_left == 0);
        end else if (rsp_count >= next_stall_at) begin
            stall_left = 240;
            next_stall_at += 450;
            rsp_if.ready <= 1'b0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            ready_gap = pick_gap();
            rsp_if.ready <= (ready_gap == 0);
        end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_if.ready <= (ready_gap == 0);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_count <= rsp_count + 1;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with nothing pending: hit=%0b read_value=%h",
                         $time, rsp_if.hit, rsp_if.read_value);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (want.hit) hits_seen++;
                if (rsp_if.hit !== want.hit) begin
                    $display("%0t: hit mismatch: expected %0b actual %0b",
                             $time, want.hit, rsp_if.hit);
                    errors++;
                end
                if (rsp_if.read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch: expected %h actual %h",
                             $time, want.read_value, rsp_if.read_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items queued and %0d replies pending",
                     $time, request_q.size(), pending_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_request(input logic op, input logic [31:0] key, input logic [31:0] value);
        t_request r;
        r.op    = op;
        r.key   = key;
        r.value = value;
        request_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || req_if.valid || pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        settings_n++;
    endtask

    task automatic queue_phase(input int eff, input int n);
        logic [31:0] pool[24];
        logic [31:0] edge_keys[4];
        logic [31:0] k;
        int pool_n;
        int r;
        edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        pool_n = eff + $urandom_range(1, 4);
        foreach (pool[i]) pool[i] = $urandom;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 80) k = pool[$urandom_range(0, pool_n - 1)];
            else if (r < 90) k = $urandom;
            else k = edge_keys[$urandom_range(0, 3)];
            queue_request($urandom_range(0, 1) ? OP_SET : OP_GET, k, $urandom);
        end
    endtask

    initial begin
        int caps[10];
        int eff;
        caps = '{1, 0, 31, 17, 16, 2, 9, 4, 12, 3};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.op    = OP_GET;
        req_if.key   = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;

        queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(OP_SET, 32'h0000_0000, 32'h7FFF_FFFF);
        queue_request(OP_SET, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_request(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_request(OP_SET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(OP_GET, 32'h8000_0000, 32'h1234_5678);
        queue_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(OP_SET, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(OP_GET, 32'h5555_5555, 32'hDEAD_BEEF);
        queue_request(OP_SET, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_request(OP_SET, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_request(OP_GET, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
        queue_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
        queue_request(OP_SET, 32'h5555_5555, 32'h0000_0001);
        queue_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
        queue_request(OP_GET, 32'h0000_0001, 32'h0000_0000);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        foreach (caps[p]) begin
            write_capacity(CAP_W'(caps[p]));
            eff = (caps[p] == 0) ? 1 : ((caps[p] > ENTRIES) ? ENTRIES : caps[p]);
            calm = ($urandom_range(0, 3) == 0);
            queue_phase(eff, 108);
            wait_idle();
        end

        $display("Ran %0d get/set items with %0d hits across %0d capacity settings",
                 accepted_n, hits_seen, settings_n);
        $display("Capacities covered zero, one, full, above full and lowered below fill");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
